### rtl/image_header_size_probe_core_defines.svh
// Assertion macros shared by the checkers of the image header size probe.
// Both sample on the rising edge of clock and are switched off while reset is high.
`ifndef IMAGE_HEADER_SIZE_PROBE_CORE_DEFINES_SVH
`define IMAGE_HEADER_SIZE_PROBE_CORE_DEFINES_SVH

// Same-cycle implication
`define IHSP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define IHSP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ihsp_pkg.sv
package ihsp_pkg;

   // Bytes of the file head kept for the format decision
   localparam int PREFIX_DEPTH = 26;
   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] POS_MAX = 5'd31;

   // Result format codes
   localparam logic [2:0] FMT_NONE = 3'd0;
   localparam logic [2:0] FMT_PNG  = 3'd1;
   localparam logic [2:0] FMT_JPEG = 3'd2;
   localparam logic [2:0] FMT_GIF  = 3'd3;
   localparam logic [2:0] FMT_BMP  = 3'd4;

   // JPEG walker status
   localparam logic [1:0] ST_SEARCHING = 2'd0;
   localparam logic [1:0] ST_FOUND     = 2'd1;
   localparam logic [1:0] ST_FAILED    = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  format_code;
      logic [30:0] width;
      logic [30:0] height;
   } rsp_type;

   // Snapshot of a finished file, handed from the tracker to the judge
   typedef struct packed {
      logic                             valid;
      logic [POS_W-1:0]                 count;
      logic [PREFIX_DEPTH-1:0][7:0]     prefix;
      logic [1:0]                       jpeg_status;
      logic [15:0]                      jpeg_width;
      logic [15:0]                      jpeg_height;
   } probe_type;

endpackage

### rtl/image_header_size_probe_core.sv
// Image header size probe.
// The req channel carries a file one byte per transaction, from offset zero, with
// last_byte set on the final byte. The rsp channel carries one transaction per
// file, issued for the byte that has last_byte set: format_code (none, PNG, JPEG,
// GIF, BMP) with width and height, both zero when the format is none.
// Both channels use valid and stall; a transaction moves when valid is high and
// stall is low.
// A result reaches rsp through the tracker snapshot and the result register.
// Throughput: one byte per cycle unless a finished file waits for the judge; the
// input register, tracker and result register each take a byte or snapshot a cycle.
// A new file may follow the last byte of the previous one in the next cycle.
// Reset clears all control state; the first byte after reset is offset zero.
// When the receiver stalls, the result is held and bytes keep flowing until the
// next file's last byte has filled the tracker snapshot; req_stall then rises on
// the byte after it and stays high until the held result is taken.
module image_header_size_probe_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ihsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ihsp_pkg::rsp_type rsp_data
);
   import ihsp_pkg::*;

   logic      in_valid_ff, in_valid_in;
   req_type   in_ff;
   probe_type snap;
   logic      take;
   logic      go;

   // Process the held byte unless a finished file still waits for the judge
   assign go        = in_valid_ff && (!snap.valid || take);
   assign req_stall = in_valid_ff && !go;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!in_valid_ff || go) in_valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   ihsp_track u_track (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .take  (take),
      .item  (in_ff),
      .snap  (snap)
   );

   ihsp_judge u_judge (
      .clock     (clock),
      .reset     (reset),
      .snap      (snap),
      .rsp_stall (rsp_stall),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/ihsp_track.sv
module ihsp_track (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic               take,
   input  ihsp_pkg::req_type  item,
   output ihsp_pkg::probe_type snap
);
   import ihsp_pkg::*;

   localparam logic [2:0] PH_PREFIX = 3'd0;
   localparam logic [2:0] PH_MARKER = 3'd1;
   localparam logic [2:0] PH_LEN_HI = 3'd2;
   localparam logic [2:0] PH_LEN_LO = 3'd3;
   localparam logic [2:0] PH_FRAME  = 3'd4;
   localparam logic [2:0] PH_SKIP   = 3'd5;

   localparam logic [7:0] MK_FILL = 8'hFF;
   localparam logic [7:0] MK_TEM  = 8'h01;
   localparam logic [7:0] MK_RST0 = 8'hD0;
   localparam logic [7:0] MK_EOI  = 8'hD9;
   localparam logic [7:0] MK_DHT  = 8'hC4;
   localparam logic [7:0] MK_JPG  = 8'hC8;
   localparam logic [7:0] MK_DAC  = 8'hCC;

   logic                         fresh_ff;
   logic                         valid_ff, valid_in;
   logic [POS_W-1:0]             pos_ff, pos_in, pos_base;
   logic [PREFIX_DEPTH-1:0][7:0] prefix_ff;
   logic [2:0]                   phase_ff, phase_in, phase_base;
   logic                         sof_ff, sof_in, sof_base;
   logic [15:0]                  skip_ff, skip_in, skip_base;
   logic [2:0]                   field_ff, field_in, field_base;
   logic [15:0]                  width_ff, width_in, width_base;
   logic [15:0]                  height_ff, height_in, height_base;
   logic [1:0]                   status_ff, status_in, status_base;
   logic [7:0]                   b;
   logic [15:0]                  seg_len;
   logic [15:0]                  seg_rest;

   assign b        = item.data_byte;
   assign seg_len  = {skip_base[15:8], b};
   assign seg_rest = seg_len - 16'd2;

   // Start from reset values on the first byte of a new file
   always_comb begin
      pos_base    = fresh_ff ? '0 : pos_ff;
      phase_base  = fresh_ff ? PH_PREFIX : phase_ff;
      sof_base    = fresh_ff ? 1'b0 : sof_ff;
      skip_base   = fresh_ff ? '0 : skip_ff;
      field_base  = fresh_ff ? '0 : field_ff;
      width_base  = fresh_ff ? '0 : width_ff;
      height_base = fresh_ff ? '0 : height_ff;
      status_base = fresh_ff ? ST_SEARCHING : status_ff;
   end

   // Advance the byte count and walk the JPEG marker segments
   always_comb begin
      pos_in    = (pos_base != POS_MAX) ? pos_base + 1'b1 : pos_base;
      phase_in  = phase_base;
      sof_in    = sof_base;
      skip_in   = skip_base;
      field_in  = field_base;
      width_in  = width_base;
      height_in = height_base;
      status_in = status_base;
      if (pos_base >= POS_W'(2) && status_base == ST_SEARCHING) begin
         case (phase_base)
            PH_PREFIX: begin
               if (b != MK_FILL) status_in = ST_FAILED;
               else              phase_in  = PH_MARKER;
            end
            PH_MARKER: begin
               if (b == MK_FILL) begin
                  phase_in = PH_MARKER;
               end else if (b == MK_TEM || (b >= MK_RST0 && b <= MK_EOI)) begin
                  phase_in = PH_PREFIX;
               end else begin
                  sof_in   = (b[7:4] == 4'hC) && b != MK_DHT && b != MK_JPG && b != MK_DAC;
                  phase_in = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               skip_in  = {b, 8'h00};
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (sof_base) begin
                  field_in = '0;
                  phase_in = PH_FRAME;
               end else if (seg_len < 16'd2) begin
                  status_in = ST_FAILED;
               end else begin
                  skip_in  = seg_rest;
                  phase_in = (seg_rest == 16'd0) ? PH_PREFIX : PH_SKIP;
               end
            end
            PH_FRAME: begin
               case (field_base)
                  3'd1:    height_in = {b, 8'h00};
                  3'd2:    height_in = {height_base[15:8], b};
                  3'd3:    width_in  = {b, 8'h00};
                  3'd4: begin
                     width_in  = {width_base[15:8], b};
                     status_in = ST_FOUND;
                  end
                  default: field_in = field_base;
               endcase
               field_in = field_base + 3'd1;
            end
            PH_SKIP: begin
               skip_in = skip_base - 16'd1;
               if (skip_base == 16'd1) phase_in = PH_PREFIX;
            end
            default: status_in = ST_FAILED;
         endcase
      end
   end

   // Hold the snapshot until the judge takes it
   always_comb begin
      valid_in = valid_ff;
      if (go && item.last_byte) valid_in = 1'b1;
      else if (take)            valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff  <= 1'b1;
         valid_ff  <= 1'b0;
         pos_ff    <= '0;
         phase_ff  <= PH_PREFIX;
         sof_ff    <= 1'b0;
         skip_ff   <= '0;
         field_ff  <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         status_ff <= ST_SEARCHING;
      end else begin
         valid_ff <= valid_in;
         if (go) begin
            fresh_ff  <= item.last_byte;
            pos_ff    <= pos_in;
            phase_ff  <= phase_in;
            sof_ff    <= sof_in;
            skip_ff   <= skip_in;
            field_ff  <= field_in;
            width_ff  <= width_in;
            height_ff <= height_in;
            status_ff <= status_in;
         end
      end
   end

   // Capture the file head
   always_ff @(posedge clock) begin
      if (go && pos_base < POS_W'(PREFIX_DEPTH)) begin
         prefix_ff[pos_base] <= b;
      end
   end

   assign snap.valid       = valid_ff;
   assign snap.count       = pos_ff;
   assign snap.prefix      = prefix_ff;
   assign snap.jpeg_status = status_ff;
   assign snap.jpeg_width  = width_ff;
   assign snap.jpeg_height = height_ff;

endmodule

### rtl/ihsp_judge.sv
module ihsp_judge (
   input  logic                clock,
   input  logic                reset,
   input  ihsp_pkg::probe_type snap,
   input  logic                rsp_stall,
   output logic                take,
   output logic                rsp_valid,
   output ihsp_pkg::rsp_type   rsp_data
);
   import ihsp_pkg::*;

   localparam logic [63:0] SIG_PNG   = 64'h89504E470D0A1A0A;
   localparam logic [31:0] TAG_IHDR  = 32'h49484452;
   localparam logic [47:0] SIG_GIF87 = 48'h474946383761;
   localparam logic [47:0] SIG_GIF89 = 48'h474946383961;
   localparam logic [15:0] SIG_BMP   = 16'h424D;
   localparam logic [15:0] SIG_JPEG  = 16'hFFD8;
   localparam logic [31:0] BMP_CORE  = 32'd12;
   localparam logic [31:0] BMP_INFO  = 32'd40;
   localparam logic [31:0] MIN_NEG   = 32'h80000000;

   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_data_ff;
   rsp_type                      result;
   logic [PREFIX_DEPTH-1:0][7:0] p;
   logic [POS_W-1:0]             cnt;
   logic [31:0]                  head_size;
   logic [31:0]                  bmp_h;
   logic [31:0]                  x, y;
   logic [2:0]                   f;

   assign p         = snap.prefix;
   assign cnt       = snap.count;
   assign head_size = {p[17], p[16], p[15], p[14]};
   assign bmp_h     = {p[25], p[24], p[23], p[22]};

   // Decide the format from the file head
   always_comb begin
      f = FMT_NONE;
      x = '0;
      y = '0;
      if (cnt >= POS_W'(8) && {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]} == SIG_PNG) begin
         if (cnt >= POS_W'(24) && {p[12], p[13], p[14], p[15]} == TAG_IHDR) begin
            f = FMT_PNG;
            x = {p[16], p[17], p[18], p[19]};
            y = {p[20], p[21], p[22], p[23]};
         end
      end else if (cnt >= POS_W'(2) && {p[0], p[1]} == SIG_JPEG) begin
         if (snap.jpeg_status == ST_FOUND) begin
            f = FMT_JPEG;
            x = {16'h0000, snap.jpeg_width};
            y = {16'h0000, snap.jpeg_height};
         end
      end else if (cnt >= POS_W'(6) && ({p[0], p[1], p[2], p[3], p[4], p[5]} == SIG_GIF87 ||
                                        {p[0], p[1], p[2], p[3], p[4], p[5]} == SIG_GIF89)) begin
         if (cnt >= POS_W'(10)) begin
            f = FMT_GIF;
            x = {16'h0000, p[7], p[6]};
            y = {16'h0000, p[9], p[8]};
         end
      end else if (cnt >= POS_W'(PREFIX_DEPTH) && {p[0], p[1]} == SIG_BMP) begin
         if (head_size == BMP_CORE) begin
            f = FMT_BMP;
            x = {16'h0000, p[19], p[18]};
            y = {16'h0000, p[21], p[20]};
         end else if (head_size >= BMP_INFO) begin
            f = FMT_BMP;
            x = {p[21], p[20], p[19], p[18]};
            // Take the magnitude of a negative height
            y = (bmp_h[31] && bmp_h != MIN_NEG) ? 32'd0 - bmp_h : bmp_h;
         end
      end
      // Drop sizes that are not positive
      if (x == '0 || y == '0 || x[31] || y[31]) begin
         f = FMT_NONE;
         x = '0;
         y = '0;
      end
      result.format_code = f;
      result.width       = x[30:0];
      result.height      = y[30:0];
   end

   assign take = snap.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take)           rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result register while the receiver stalls
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/ihsp_checker.sv
`include "image_header_size_probe_core_defines.svh"

module ihsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ihsp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ihsp_pkg::rsp_type rsp_data
);
   import ihsp_pkg::*;

   // A stalled result stays put
   `IHSP_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp payload changed while stalled")

   // No format means no sizes
   `IHSP_ASSERT_IMP(a_none_zero, rsp_valid && rsp_data.format_code == FMT_NONE, rsp_data.width == '0 && rsp_data.height == '0, "sizes reported without a format")

   // A recognised format has positive sizes
   `IHSP_ASSERT_IMP(a_found_pos, rsp_valid && rsp_data.format_code != FMT_NONE, rsp_data.width != '0 && rsp_data.height != '0, "format reported with a zero size")

   // Input backpressure only comes from a stalled result
   `IHSP_ASSERT_IMP(a_stall_src, req_stall, rsp_valid && rsp_stall, "req stalled without a stalled result")

endmodule

bind image_header_size_probe_core ihsp_checker u_checker (.*);
